[design/mhps_pkg.sv]
`default_nettype none

package mhps_pkg;

  // Request codes.
  localparam logic [2:0] REQ_TICK    = 3'd0;
  localparam logic [2:0] REQ_SETPT   = 3'd1;
  localparam logic [2:0] REQ_HOME    = 3'd2;
  localparam logic [2:0] REQ_STOP    = 3'd3;
  localparam logic [2:0] REQ_MAN_FWD = 3'd4;
  localparam logic [2:0] REQ_MAN_REV = 3'd5;

  // Phase codes.
  localparam logic [2:0] PH_IDLE     = 3'd0;
  localparam logic [2:0] PH_HOME_REV = 3'd1;
  localparam logic [2:0] PH_HOME_FWD = 3'd2;
  localparam logic [2:0] PH_FINDING  = 3'd3;
  localparam logic [2:0] PH_MAN_FWD  = 3'd4;
  localparam logic [2:0] PH_MAN_REV  = 3'd5;

  // Drive mode codes.
  localparam logic [2:0] DRV_NONE      = 3'd0;
  localparam logic [2:0] DRV_VOLTAGE   = 3'd1;
  localparam logic [2:0] DRV_DUTY      = 3'd2;
  localparam logic [2:0] DRV_POS       = 3'd3;
  localparam logic [2:0] DRV_SMART_POS = 3'd4;
  localparam logic [2:0] DRV_VEL       = 3'd5;
  localparam logic [2:0] DRV_SMART_VEL = 3'd6;

  // Configuration register indexes.
  localparam logic [2:0] CFG_POS_LOWER  = 3'd0;
  localparam logic [2:0] CFG_POS_UPPER  = 3'd1;
  localparam logic [2:0] CFG_VEL_LOWER  = 3'd2;
  localparam logic [2:0] CFG_VEL_UPPER  = 3'd3;
  localparam logic [2:0] CFG_TOLERANCE  = 3'd4;
  localparam logic [2:0] CFG_TIMEOUTS   = 3'd5;
  localparam logic [2:0] CFG_SPEEDS     = 3'd6;
  localparam logic [2:0] CFG_MODE_FLAGS = 3'd7;

  // Mode flag bit positions.
  localparam int FLAG_BACK_OFF = 0;
  localparam int FLAG_FWD_NO   = 1;
  localparam int FLAG_REV_NO   = 2;
  localparam int FLAG_SMART    = 3;

  // Bus voltage below which the motor counts as settled, in mV.
  localparam logic [16:0] BUS_LIMIT_MV = 17'd1000;

  typedef struct packed {
    logic [2:0]         req_type;
    logic signed [31:0] target_value;
    logic               target_is_position;
    logic               fwd_switch_level;
    logic               rev_switch_level;
    logic signed [31:0] measured_value;
    logic signed [15:0] bus_voltage_mv;
    logic [31:0]        time_ms;
  } req_t;

  typedef struct packed {
    logic [2:0]         drive_mode;
    logic signed [31:0] drive_value;
    logic               ready_res;
    logic               homed;
    logic [2:0]         phase;
  } res_t;

  typedef struct packed {
    logic signed [31:0] pos_lower_limit;
    logic signed [31:0] pos_upper_limit;
    logic signed [31:0] vel_lower_limit;
    logic signed [31:0] vel_upper_limit;
    logic [30:0]        tolerance;
    logic [31:0]        home_timeout_ms;
    logic [31:0]        find_timeout_ms;
    logic signed [15:0] speed_fwd_home;
    logic signed [15:0] speed_rev_home;
    logic signed [15:0] speed_man_fwd;
    logic signed [15:0] speed_man_rev;
    logic [3:0]         mode_flags;
  } cfg_t;

endpackage

`default_nettype wire

[design/mhps_cfg.sv]
`default_nettype none

module mhps_cfg (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            cfg_we,
  input  wire logic [2:0]      cfg_index,
  input  wire logic [63:0]     cfg_data,
  output mhps_pkg::cfg_t       cfg
);

  mhps_pkg::cfg_t regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.pos_lower_limit <= 32'sh8000_0000;
      regs.pos_upper_limit <= 32'sh7FFF_FFFF;
      regs.vel_lower_limit <= 32'sh8000_0000;
      regs.vel_upper_limit <= 32'sh7FFF_FFFF;
      regs.tolerance       <= 31'd65536;
      regs.home_timeout_ms <= '0;
      regs.find_timeout_ms <= '0;
      regs.speed_fwd_home  <= '0;
      regs.speed_rev_home  <= '0;
      regs.speed_man_fwd   <= '0;
      regs.speed_man_rev   <= '0;
      regs.mode_flags      <= 4'd7;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mhps_pkg::CFG_POS_LOWER:  regs.pos_lower_limit <= cfg_data[31:0];
        mhps_pkg::CFG_POS_UPPER:  regs.pos_upper_limit <= cfg_data[31:0];
        mhps_pkg::CFG_VEL_LOWER:  regs.vel_lower_limit <= cfg_data[31:0];
        mhps_pkg::CFG_VEL_UPPER:  regs.vel_upper_limit <= cfg_data[31:0];
        mhps_pkg::CFG_TOLERANCE:  regs.tolerance       <= cfg_data[30:0];
        mhps_pkg::CFG_TIMEOUTS: begin
          regs.home_timeout_ms <= cfg_data[31:0];
          regs.find_timeout_ms <= cfg_data[63:32];
        end
        mhps_pkg::CFG_SPEEDS: begin
          regs.speed_fwd_home <= cfg_data[15:0];
          regs.speed_rev_home <= cfg_data[31:16];
          regs.speed_man_fwd  <= cfg_data[47:32];
          regs.speed_man_rev  <= cfg_data[63:48];
        end
        mhps_pkg::CFG_MODE_FLAGS: regs.mode_flags <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  assign cfg = regs;

endmodule

`default_nettype wire

[design/mhps_core.sv]
`default_nettype none

module mhps_core (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            step,
  input  wire mhps_pkg::req_t  item,
  input  wire mhps_pkg::cfg_t  cfg,
  output mhps_pkg::res_t       result
);

  logic [2:0]         phase_reg;
  logic               ready_flag;
  logic               homed_flag;
  logic signed [31:0] setpoint_reg;
  logic [31:0]        homing_start;
  logic [31:0]        finding_start;

  logic [2:0]         phase_next;
  logic               ready_next;
  logic               homed_next;
  logic signed [31:0] setpoint_next;
  logic [31:0]        homing_start_next;
  logic [31:0]        finding_start_next;
  logic [2:0]         mode;
  logic signed [31:0] value;

  logic               fwd_pressed;
  logic               rev_pressed;
  logic               home_expired;
  logic               find_expired;
  logic [31:0]        home_elapsed;
  logic [31:0]        find_elapsed;
  logic signed [32:0] err;
  logic [32:0]        err_mag;
  logic [16:0]        bus_mag;
  logic               at_setpoint;
  logic               sp_above;
  logic               sp_below;
  logic signed [31:0] lim_hi;
  logic signed [31:0] lim_lo;
  logic signed [31:0] clamped;
  logic               smart;

  // A normally open switch reads pressed at level 1, a normally closed one at 0.
  assign fwd_pressed = item.fwd_switch_level == cfg.mode_flags[mhps_pkg::FLAG_FWD_NO];
  assign rev_pressed = item.rev_switch_level == cfg.mode_flags[mhps_pkg::FLAG_REV_NO];
  assign smart       = cfg.mode_flags[mhps_pkg::FLAG_SMART];

  assign home_elapsed = item.time_ms - homing_start;
  assign find_elapsed = item.time_ms - finding_start;
  assign home_expired = (cfg.home_timeout_ms != '0) && (home_elapsed > cfg.home_timeout_ms);
  assign find_expired = (cfg.find_timeout_ms != '0) && (find_elapsed > cfg.find_timeout_ms);

  assign err     = {setpoint_reg[31], setpoint_reg}
                 - {item.measured_value[31], item.measured_value};
  assign err_mag = err[32] ? 33'(-err) : 33'(err);
  assign bus_mag = item.bus_voltage_mv[15]
                 ? 17'(-{item.bus_voltage_mv[15], item.bus_voltage_mv})
                 : {1'b0, item.bus_voltage_mv};
  assign at_setpoint = (err_mag < {2'b00, cfg.tolerance}) && (bus_mag < mhps_pkg::BUS_LIMIT_MV);
  assign sp_above    = setpoint_reg > item.measured_value;
  assign sp_below    = setpoint_reg < item.measured_value;

  assign lim_hi = item.target_is_position ? cfg.pos_upper_limit : cfg.vel_upper_limit;
  assign lim_lo = item.target_is_position ? cfg.pos_lower_limit : cfg.vel_lower_limit;
  // The upper bound wins when the limits cross.
  assign clamped = (item.target_value > lim_hi) ? lim_hi
                 : (item.target_value < lim_lo) ? lim_lo : item.target_value;

  always_comb begin
    phase_next         = phase_reg;
    ready_next         = ready_flag;
    homed_next         = homed_flag;
    setpoint_next      = setpoint_reg;
    homing_start_next  = homing_start;
    finding_start_next = finding_start;
    mode               = mhps_pkg::DRV_NONE;
    value              = '0;

    unique case (item.req_type)
      mhps_pkg::REQ_TICK: begin
        unique case (phase_reg)
          mhps_pkg::PH_IDLE: begin
            mode       = mhps_pkg::DRV_VOLTAGE;
            ready_next = 1'b1;
          end
          mhps_pkg::PH_HOME_REV: begin
            ready_next = 1'b0;
            if (rev_pressed || home_expired) begin
              mode = mhps_pkg::DRV_VOLTAGE;
              if (cfg.mode_flags[mhps_pkg::FLAG_BACK_OFF]) begin
                phase_next = mhps_pkg::PH_HOME_FWD;
              end else begin
                homed_next = 1'b1;
                phase_next = mhps_pkg::PH_IDLE;
              end
            end else begin
              mode  = mhps_pkg::DRV_DUTY;
              value = {{16{cfg.speed_rev_home[15]}}, cfg.speed_rev_home};
            end
          end
          mhps_pkg::PH_HOME_FWD: begin
            ready_next = 1'b0;
            if (!rev_pressed || home_expired) begin
              mode       = mhps_pkg::DRV_POS;
              homed_next = 1'b1;
              phase_next = mhps_pkg::PH_IDLE;
            end else begin
              mode  = mhps_pkg::DRV_DUTY;
              value = {{16{cfg.speed_fwd_home[15]}}, cfg.speed_fwd_home};
            end
          end
          mhps_pkg::PH_FINDING: begin
            ready_next = 1'b0;
            if (at_setpoint || (sp_above && fwd_pressed) || (sp_below && rev_pressed)
                || find_expired) begin
              mode       = mhps_pkg::DRV_DUTY;
              phase_next = mhps_pkg::PH_IDLE;
            end
          end
          mhps_pkg::PH_MAN_FWD: begin
            if (!fwd_pressed) begin
              mode       = mhps_pkg::DRV_DUTY;
              value      = {{16{cfg.speed_man_fwd[15]}}, cfg.speed_man_fwd};
              ready_next = 1'b0;
            end else begin
              phase_next = mhps_pkg::PH_IDLE;
              ready_next = 1'b1;
            end
          end
          mhps_pkg::PH_MAN_REV: begin
            if (!rev_pressed) begin
              mode       = mhps_pkg::DRV_DUTY;
              value      = {{16{cfg.speed_man_rev[15]}}, cfg.speed_man_rev};
              ready_next = 1'b0;
            end else begin
              phase_next = mhps_pkg::PH_IDLE;
              ready_next = 1'b1;
            end
          end
          default: ;
        endcase
      end
      mhps_pkg::REQ_SETPT: begin
        setpoint_next      = clamped;
        value              = clamped;
        finding_start_next = item.time_ms;
        phase_next         = mhps_pkg::PH_FINDING;
        if (item.target_is_position) begin
          mode = smart ? mhps_pkg::DRV_SMART_POS : mhps_pkg::DRV_POS;
        end else begin
          mode = smart ? mhps_pkg::DRV_SMART_VEL : mhps_pkg::DRV_VEL;
        end
      end
      mhps_pkg::REQ_HOME: begin
        mode              = mhps_pkg::DRV_DUTY;
        homing_start_next = item.time_ms;
        homed_next        = 1'b0;
        phase_next        = mhps_pkg::PH_HOME_REV;
      end
      mhps_pkg::REQ_STOP: begin
        mode       = mhps_pkg::DRV_DUTY;
        phase_next = mhps_pkg::PH_IDLE;
      end
      mhps_pkg::REQ_MAN_FWD: phase_next = mhps_pkg::PH_MAN_FWD;
      mhps_pkg::REQ_MAN_REV: phase_next = mhps_pkg::PH_MAN_REV;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_reg     <= mhps_pkg::PH_IDLE;
      ready_flag    <= 1'b1;
      homed_flag    <= 1'b0;
      setpoint_reg  <= '0;
      homing_start  <= '0;
      finding_start <= '0;
    end else if (step) begin
      phase_reg     <= phase_next;
      ready_flag    <= ready_next;
      homed_flag    <= homed_next;
      setpoint_reg  <= setpoint_next;
      homing_start  <= homing_start_next;
      finding_start <= finding_start_next;
    end
  end

  assign result.drive_mode  = mode;
  assign result.drive_value = value;
  assign result.ready_res   = ready_next;
  assign result.homed       = homed_next;
  assign result.phase       = phase_next;

  // State only moves on a processed beat.
  a_hold_when_idle: assert property (@(posedge clk) disable iff (rst)
    !step |=> $stable(phase_reg) && $stable(homed_flag) && $stable(setpoint_reg))
    else $error("sequencer state changed without a beat");

  a_home_clears: assert property (@(posedge clk) disable iff (rst)
    step && item.req_type == mhps_pkg::REQ_HOME
    |=> !homed_flag && phase_reg == mhps_pkg::PH_HOME_REV && homing_start == $past(item.time_ms))
    else $error("start homing did not arm the homing sequence");

  a_homed_source: assert property (@(posedge clk) disable iff (rst)
    step && homed_next && !homed_flag
    |-> phase_reg == mhps_pkg::PH_HOME_REV || phase_reg == mhps_pkg::PH_HOME_FWD)
    else $error("homed flag set outside of a homing phase");

  a_setpoint_in_limits: assert property (@(posedge clk) disable iff (rst)
    step && item.req_type == mhps_pkg::REQ_SETPT && lim_lo <= lim_hi
    |-> setpoint_next >= lim_lo && setpoint_next <= lim_hi)
    else $error("setpoint escaped the soft limits");

endmodule

`default_nettype wire

[design/motor_homing_positioning_sequencer_top.sv]
`default_nettype none

// Homing and positioning sequencer for one motor. Every request beat (a tick
// or a command) yields exactly one result beat carrying the drive command, the
// ready and homed flags and the phase. One beat is accepted per clock while
// the result register is not stalled. An accepted beat goes into the input
// register, passes the combinational sequencer logic into the result register
// once that register is free, and is presented on the result channel from
// then on. The rate is set by that one pass of compare-and-select logic, which
// updates the sequencer state in the same cycle it fills the result register.
// While the result register is stalled, the input register still takes one
// beat. Configuration writes take effect on the next clock; configuration
// writes are to be made by the user only while no beat is in flight, which the
// block itself does not enforce.
module motor_homing_positioning_sequencer_top (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           req_valid,
  output logic                req_stall,
  input  wire mhps_pkg::req_t req,
  output logic                res_valid,
  input  wire logic           res_stall,
  output mhps_pkg::res_t      res,
  input  wire logic           cfg_we,
  input  wire logic [2:0]     cfg_index,
  input  wire logic [63:0]    cfg_data
);

  mhps_pkg::cfg_t cfg;
  mhps_pkg::req_t req_q;
  mhps_pkg::res_t res_q;
  mhps_pkg::res_t step_res;
  logic           req_q_valid;
  logic           res_free;
  logic           step;
  logic           req_take;

  assign res_free  = !res_valid || !res_stall;
  assign step      = req_q_valid && res_free;
  assign req_stall = req_q_valid && !res_free;
  assign req_take  = req_valid && !req_stall;

  mhps_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  mhps_core u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .item   (req_q),
    .cfg    (cfg),
    .result (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      req_q_valid <= 1'b0;
    end else if (req_take) begin
      req_q_valid <= 1'b1;
    end else if (step) begin
      req_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_take) begin
      req_q <= req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_free) begin
      res_valid <= step;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_q <= step_res;
    end
  end

  assign res = res_q;

endmodule

`default_nettype wire

[dv/tb.sv]
`timescale 1ns / 100ps

module tb;

  // Request codes that the block has no use for.
  localparam logic [2:0] REQ_UNUSED6 = 3'd6;
  localparam logic [2:0] REQ_UNUSED7 = 3'd7;

  localparam int N_PHASES = 12;
  localparam int BEATS_PER_PHASE = 165;
  localparam int CYCLE_LIMIT = 1000000;

  typedef struct {
    mhps_pkg::req_t beat;
    bit             typed;
    mhps_pkg::res_t want;
  } row_t;

  logic           clk = 1'b0;
  logic           rst;
  logic           req_valid;
  logic           req_stall;
  mhps_pkg::req_t req_beat;
  logic           res_valid;
  logic           res_stall;
  mhps_pkg::res_t res_beat;
  logic           cfg_we;
  logic [2:0]     cfg_index;
  logic [63:0]    cfg_data;

  // Shadow of the sequencer state and its registers.
  mhps_pkg::cfg_t     cfg_shadow;
  logic [2:0]         m_phase;
  logic               m_ready;
  logic               m_homed;
  logic signed [31:0] m_setpoint;
  logic               m_pos_mode;
  logic [31:0]        m_home_t0;
  logic [31:0]        m_find_t0;

  mhps_pkg::res_t drive_pending[$];
  logic [31:0]    now_ms;
  int             gap_pct = 30;
  int             stall_pct = 30;
  int             n_beats = 0;
  int             n_errors = 0;
  int             n_cycles = 0;

  motor_homing_positioning_sequencer_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req_beat),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res_beat),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic int idle_len(input int pct);
    if ($urandom_range(0, 99) >= pct) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(8, 40);
    return $urandom_range(1, 3);
  endfunction

  task automatic reset_shadow();
    cfg_shadow.pos_lower_limit = 32'sh8000_0000;
    cfg_shadow.pos_upper_limit = 32'sh7FFF_FFFF;
    cfg_shadow.vel_lower_limit = 32'sh8000_0000;
    cfg_shadow.vel_upper_limit = 32'sh7FFF_FFFF;
    cfg_shadow.tolerance       = 31'd65536;
    cfg_shadow.home_timeout_ms = '0;
    cfg_shadow.find_timeout_ms = '0;
    cfg_shadow.speed_fwd_home  = '0;
    cfg_shadow.speed_rev_home  = '0;
    cfg_shadow.speed_man_fwd   = '0;
    cfg_shadow.speed_man_rev   = '0;
    cfg_shadow.mode_flags      = 4'd7;
    m_phase    = mhps_pkg::PH_IDLE;
    m_ready    = 1'b1;
    m_homed    = 1'b0;
    m_setpoint = '0;
    m_pos_mode = 1'b1;
    m_home_t0  = '0;
    m_find_t0  = '0;
  endtask

  // Drive command and flags that one request beat produces; advances the shadow state.
  function automatic mhps_pkg::res_t next_drive(input mhps_pkg::req_t r);
    mhps_pkg::res_t     o;
    logic               fwd_hit, rev_hit, home_out, find_out, at_sp, smart;
    longint             err;
    int                 bus;
    logic signed [31:0] hi, lo, t;
    o = '0;
    smart    = cfg_shadow.mode_flags[mhps_pkg::FLAG_SMART];
    fwd_hit  = r.fwd_switch_level == cfg_shadow.mode_flags[mhps_pkg::FLAG_FWD_NO];
    rev_hit  = r.rev_switch_level == cfg_shadow.mode_flags[mhps_pkg::FLAG_REV_NO];
    home_out = cfg_shadow.home_timeout_ms != 0 &&
               32'(r.time_ms - m_home_t0) > cfg_shadow.home_timeout_ms;
    find_out = cfg_shadow.find_timeout_ms != 0 &&
               32'(r.time_ms - m_find_t0) > cfg_shadow.find_timeout_ms;
    err = longint'(m_setpoint) - longint'(r.measured_value);
    if (err < 0) err = -err;
    bus = r.bus_voltage_mv;
    if (bus < 0) bus = -bus;
    at_sp = err < longint'(cfg_shadow.tolerance) && bus < 1000;

    case (r.req_type)
      mhps_pkg::REQ_TICK: begin
        case (m_phase)
          mhps_pkg::PH_IDLE: begin
            o.drive_mode = mhps_pkg::DRV_VOLTAGE;
            m_ready = 1'b1;
          end
          mhps_pkg::PH_HOME_REV: begin
            m_ready = 1'b0;
            if (rev_hit || home_out) begin
              o.drive_mode = mhps_pkg::DRV_VOLTAGE;
              if (cfg_shadow.mode_flags[mhps_pkg::FLAG_BACK_OFF]) begin
                m_phase = mhps_pkg::PH_HOME_FWD;
              end else begin
                m_homed = 1'b1;
                m_phase = mhps_pkg::PH_IDLE;
              end
            end else begin
              o.drive_mode  = mhps_pkg::DRV_DUTY;
              o.drive_value = cfg_shadow.speed_rev_home;
            end
          end
          mhps_pkg::PH_HOME_FWD: begin
            m_ready = 1'b0;
            if (!rev_hit || home_out) begin
              o.drive_mode = mhps_pkg::DRV_POS;
              m_homed = 1'b1;
              m_phase = mhps_pkg::PH_IDLE;
            end else begin
              o.drive_mode  = mhps_pkg::DRV_DUTY;
              o.drive_value = cfg_shadow.speed_fwd_home;
            end
          end
          mhps_pkg::PH_FINDING: begin
            m_ready = 1'b0;
            if (at_sp || (m_setpoint > r.measured_value && fwd_hit) ||
                (m_setpoint < r.measured_value && rev_hit) || find_out) begin
              o.drive_mode = mhps_pkg::DRV_DUTY;
              m_phase = mhps_pkg::PH_IDLE;
            end
          end
          mhps_pkg::PH_MAN_FWD: begin
            if (!fwd_hit) begin
              o.drive_mode  = mhps_pkg::DRV_DUTY;
              o.drive_value = cfg_shadow.speed_man_fwd;
              m_ready = 1'b0;
            end else begin
              m_phase = mhps_pkg::PH_IDLE;
              m_ready = 1'b1;
            end
          end
          mhps_pkg::PH_MAN_REV: begin
            if (!rev_hit) begin
              o.drive_mode  = mhps_pkg::DRV_DUTY;
              o.drive_value = cfg_shadow.speed_man_rev;
              m_ready = 1'b0;
            end else begin
              m_phase = mhps_pkg::PH_IDLE;
              m_ready = 1'b1;
            end
          end
          default: ;
        endcase
      end
      mhps_pkg::REQ_SETPT: begin
        hi = r.target_is_position ? cfg_shadow.pos_upper_limit : cfg_shadow.vel_upper_limit;
        lo = r.target_is_position ? cfg_shadow.pos_lower_limit : cfg_shadow.vel_lower_limit;
        t = r.target_value;
        // The upper clamp wins when the limits cross.
        if (t > hi) t = hi;
        else if (t < lo) t = lo;
        m_pos_mode = r.target_is_position;
        m_setpoint = t;
        if (r.target_is_position) begin
          o.drive_mode = smart ? mhps_pkg::DRV_SMART_POS : mhps_pkg::DRV_POS;
        end else begin
          o.drive_mode = smart ? mhps_pkg::DRV_SMART_VEL : mhps_pkg::DRV_VEL;
        end
        o.drive_value = t;
        m_find_t0 = r.time_ms;
        m_phase = mhps_pkg::PH_FINDING;
      end
      mhps_pkg::REQ_HOME: begin
        o.drive_mode = mhps_pkg::DRV_DUTY;
        m_home_t0 = r.time_ms;
        m_homed = 1'b0;
        m_phase = mhps_pkg::PH_HOME_REV;
      end
      mhps_pkg::REQ_STOP: begin
        o.drive_mode = mhps_pkg::DRV_DUTY;
        m_phase = mhps_pkg::PH_IDLE;
      end
      mhps_pkg::REQ_MAN_FWD: m_phase = mhps_pkg::PH_MAN_FWD;
      mhps_pkg::REQ_MAN_REV: m_phase = mhps_pkg::PH_MAN_REV;
      default: ;
    endcase
    o.ready_res = m_ready;
    o.homed     = m_homed;
    o.phase     = m_phase;
    return o;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, got);
    if (got !== want) begin
      $error("%s: expected %h, got %h", name, want, got);
      n_errors++;
    end
  endtask

  always @(posedge clk) begin
    mhps_pkg::res_t want;
    if (!rst && res_valid && !res_stall) begin
      if (drive_pending.size() == 0) begin
        $error("result beat with nothing pending: drive_mode %0d, drive_value %h",
               res_beat.drive_mode, res_beat.drive_value);
        n_errors++;
      end else begin
        want = drive_pending.pop_front();
        check_field("drive_mode", want.drive_mode, res_beat.drive_mode);
        check_field("drive_value", want.drive_value, res_beat.drive_value);
        check_field("ready_res", want.ready_res, res_beat.ready_res);
        check_field("homed", want.homed, res_beat.homed);
        check_field("phase", want.phase, res_beat.phase);
      end
    end
  end

  initial begin : stall_gen
    int hold;
    res_stall <= 1'b0;
    @(posedge clk);
    forever begin
      hold = idle_len(stall_pct);
      if (hold > 0) begin
        res_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      res_stall <= 1'b0;
      @(posedge clk);
    end
  end

  task automatic send_beat(input mhps_pkg::req_t r, input bit typed,
                           input mhps_pkg::res_t want);
    int             gap;
    mhps_pkg::res_t pred;
    gap = idle_len(gap_pct);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req_beat  <= r;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    pred = next_drive(r);
    drive_pending.push_back(typed ? want : pred);
    if (r.req_type <= mhps_pkg::REQ_MAN_REV) n_beats++;
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    while (drive_pending.size() != 0) @(posedge clk);
  endtask

  task automatic load_cfg(input mhps_pkg::cfg_t c);
    logic [63:0] w;
    for (int i = 0; i < 8; i++) begin
      w = {$urandom, $urandom};
      case (3'(i))
        mhps_pkg::CFG_POS_LOWER:  w[31:0] = c.pos_lower_limit;
        mhps_pkg::CFG_POS_UPPER:  w[31:0] = c.pos_upper_limit;
        mhps_pkg::CFG_VEL_LOWER:  w[31:0] = c.vel_lower_limit;
        mhps_pkg::CFG_VEL_UPPER:  w[31:0] = c.vel_upper_limit;
        mhps_pkg::CFG_TOLERANCE:  w[30:0] = c.tolerance;
        mhps_pkg::CFG_TIMEOUTS:   w = {c.find_timeout_ms, c.home_timeout_ms};
        mhps_pkg::CFG_SPEEDS:     w = {c.speed_man_rev, c.speed_man_fwd, c.speed_rev_home,
                                       c.speed_fwd_home};
        mhps_pkg::CFG_MODE_FLAGS: w[3:0] = c.mode_flags;
        default: ;
      endcase
      cfg_we    <= 1'b1;
      cfg_index <= 3'(i);
      cfg_data  <= w;
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    cfg_shadow = c;
  endtask

  function automatic mhps_pkg::cfg_t pick_cfg(input int k);
    mhps_pkg::cfg_t     c;
    logic signed [31:0] a, b;
    case (k)
      0: begin
        c.pos_lower_limit = 32'sh8000_0000;
        c.pos_upper_limit = 32'sh7FFF_FFFF;
        c.vel_lower_limit = 32'sh8000_0000;
        c.vel_upper_limit = 32'sh7FFF_FFFF;
        c.tolerance       = 31'h7FFF_FFFF;
        c.home_timeout_ms = '1;
        c.find_timeout_ms = '1;
        c.speed_fwd_home  = 16'sh7FFF;
        c.speed_rev_home  = 16'sh8000;
        c.speed_man_fwd   = 16'sh7FFF;
        c.speed_man_rev   = 16'sh8000;
        c.mode_flags      = 4'hF;
      end
      1: begin
        // Crossed limits and the tightest timeouts.
        c.pos_lower_limit = 32'sh7FFF_FFFF;
        c.pos_upper_limit = 32'sh8000_0000;
        c.vel_lower_limit = 32'sh0001_0000;
        c.vel_upper_limit = 32'shFFFF_0000;
        c.tolerance       = '0;
        c.home_timeout_ms = 32'd1;
        c.find_timeout_ms = 32'd1;
        c.speed_fwd_home  = 16'sh8000;
        c.speed_rev_home  = 16'sh7FFF;
        c.speed_man_fwd   = 16'sh8000;
        c.speed_man_rev   = 16'sh7FFF;
        c.mode_flags      = 4'h0;
      end
      default: begin
        a = $urandom;
        b = $urandom;
        if (a > b && $urandom_range(0, 3) != 0) {a, b} = {b, a};
        c.pos_lower_limit = a;
        c.pos_upper_limit = b;
        a = $urandom;
        b = $urandom;
        if (a > b && $urandom_range(0, 3) != 0) {a, b} = {b, a};
        c.vel_lower_limit = a;
        c.vel_upper_limit = b;
        c.tolerance = ($urandom_range(0, 7) == 0) ? 31'($urandom)
                                                  : 31'($urandom_range(0, 32'h40000));
        c.home_timeout_ms = ($urandom_range(0, 2) == 0) ? 32'd0 : $urandom_range(1, 60);
        c.find_timeout_ms = ($urandom_range(0, 2) == 0) ? 32'd0 : $urandom_range(1, 60);
        {c.speed_man_rev, c.speed_man_fwd, c.speed_rev_home, c.speed_fwd_home} =
          {$urandom, $urandom};
        c.mode_flags = 4'($urandom_range(0, 15));
      end
    endcase
    return c;
  endfunction

  function automatic logic fwd_level(input bit pressed);
    return pressed ? cfg_shadow.mode_flags[mhps_pkg::FLAG_FWD_NO]
                   : !cfg_shadow.mode_flags[mhps_pkg::FLAG_FWD_NO];
  endfunction

  function automatic logic rev_level(input bit pressed);
    return pressed ? cfg_shadow.mode_flags[mhps_pkg::FLAG_REV_NO]
                   : !cfg_shadow.mode_flags[mhps_pkg::FLAG_REV_NO];
  endfunction

  // Measured value spread around the setpoint on the scale of the tolerance.
  function automatic logic [31:0] near_setpoint();
    longint span;
    span = (cfg_shadow.tolerance > 31'h20_0000) ? 64'h20_0000
                                                : longint'(cfg_shadow.tolerance) + 2;
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return m_setpoint;
      default: return 32'(longint'(m_setpoint) +
                          longint'($urandom_range(0, 32'(2 * span))) - span);
    endcase
  endfunction

  function automatic logic [31:0] pick_target(input logic is_pos);
    int delta;
    delta = int'($urandom_range(0, 4)) - 2;
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return 32'(longint'(is_pos ? cfg_shadow.pos_upper_limit
                                    : cfg_shadow.vel_upper_limit) + delta);
      2: return 32'(longint'(is_pos ? cfg_shadow.pos_lower_limit
                                    : cfg_shadow.vel_lower_limit) + delta);
      default: return near_setpoint();
    endcase
  endfunction

  function automatic mhps_pkg::req_t fresh(input logic [2:0] kind);
    mhps_pkg::req_t r;
    now_ms += ($urandom_range(0, 15) == 0) ? $urandom_range(0, 200) : $urandom_range(0, 4);
    r.req_type           = kind;
    r.target_is_position = $urandom_range(0, 1);
    r.target_value       = pick_target(r.target_is_position);
    r.fwd_switch_level   = fwd_level($urandom_range(0, 7) == 0);
    r.rev_switch_level   = rev_level($urandom_range(0, 7) == 0);
    r.measured_value     = near_setpoint();
    r.bus_voltage_mv     = ($urandom_range(0, 7) == 0) ? 16'($urandom)
                                                       : 16'(int'($urandom_range(0, 2400)) - 1200);
    r.time_ms            = now_ms;
    return r;
  endfunction

  function automatic mhps_pkg::req_t mk(input logic [2:0] kind, input logic [31:0] target,
                                        input logic is_pos, fwd, rev,
                                        input logic [31:0] meas,
                                        input logic [15:0] bus, input logic [31:0] t);
    mhps_pkg::req_t r;
    r.req_type           = kind;
    r.target_value       = target;
    r.target_is_position = is_pos;
    r.fwd_switch_level   = fwd;
    r.rev_switch_level   = rev;
    r.measured_value     = meas;
    r.bus_voltage_mv     = bus;
    r.time_ms            = t;
    return r;
  endfunction

  // A well-formed motion with random content; now and then a stray command cuts in.
  task automatic run_sequence();
    mhps_pkg::req_t r;
    int             k;
    logic [2:0]     kind;
    k = 0;
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        send_beat(fresh(mhps_pkg::REQ_HOME), 1'b0, '0);
        while ((m_phase == mhps_pkg::PH_HOME_REV || m_phase == mhps_pkg::PH_HOME_FWD)
               && k < 30) begin
          r = fresh(mhps_pkg::REQ_TICK);
          r.rev_switch_level = rev_level(m_phase == mhps_pkg::PH_HOME_REV
                                         ? $urandom_range(0, 3) == 0
                                         : $urandom_range(0, 2) != 0);
          if ($urandom_range(0, 24) == 0) r.req_type = 3'($urandom_range(0, 7));
          send_beat(r, 1'b0, '0);
          k++;
        end
      end
      3, 4, 5: begin
        send_beat(fresh(mhps_pkg::REQ_SETPT), 1'b0, '0);
        while (m_phase == mhps_pkg::PH_FINDING && k < 20) begin
          r = fresh(mhps_pkg::REQ_TICK);
          if ($urandom_range(0, 24) == 0) r.req_type = 3'($urandom_range(0, 7));
          send_beat(r, 1'b0, '0);
          k++;
        end
      end
      6, 7: begin
        kind = $urandom_range(0, 1) ? mhps_pkg::REQ_MAN_FWD : mhps_pkg::REQ_MAN_REV;
        send_beat(fresh(kind), 1'b0, '0);
        while ((m_phase == mhps_pkg::PH_MAN_FWD || m_phase == mhps_pkg::PH_MAN_REV)
               && k < 15) begin
          r = fresh(($urandom_range(0, 9) == 0) ? mhps_pkg::REQ_STOP : mhps_pkg::REQ_TICK);
          r.fwd_switch_level = fwd_level($urandom_range(0, 3) == 0);
          r.rev_switch_level = rev_level($urandom_range(0, 3) == 0);
          send_beat(r, 1'b0, '0);
          k++;
        end
      end
      default: begin
        repeat ($urandom_range(1, 4)) begin
          r = fresh(3'($urandom_range(0, 7)));
          r.target_value     = $urandom;
          r.measured_value   = $urandom;
          r.bus_voltage_mv   = 16'($urandom);
          r.fwd_switch_level = $urandom_range(0, 1);
          r.rev_switch_level = $urandom_range(0, 1);
          if ($urandom_range(0, 3) == 0) r.time_ms = $urandom;
          send_beat(r, 1'b0, '0);
        end
      end
    endcase
  endtask

  initial begin
    row_t tbl[$];
    int   base;
    req_valid <= 1'b0;
    req_beat  <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= mhps_pkg::CFG_POS_LOWER;
    cfg_data  <= '0;
    rst       <= 1'b1;
    now_ms = '0;
    reset_shadow();

    // Both limit switches are normally open after reset: level 1 means pressed.
    tbl.push_back('{mk(mhps_pkg::REQ_TICK, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                    '{mhps_pkg::DRV_VOLTAGE, 32'sd0, 1'b1, 1'b0, mhps_pkg::PH_IDLE}});
    tbl.push_back('{mk(REQ_UNUSED6, 32'h7FFF_FFFF, 1, 1, 1, 32'h8000_0000, 16'h7FFF,
                       32'hFFFF_FFFF), 1'b1,
                    '{mhps_pkg::DRV_NONE, 32'sd0, 1'b1, 1'b0, mhps_pkg::PH_IDLE}});
    tbl.push_back('{mk(REQ_UNUSED7, 32'h8000_0000, 0, 0, 0, 32'h7FFF_FFFF, 16'h8000,
                       32'h0), 1'b1,
                    '{mhps_pkg::DRV_NONE, 32'sd0, 1'b1, 1'b0, mhps_pkg::PH_IDLE}});
    tbl.push_back('{mk(mhps_pkg::REQ_SETPT, 32'h7FFF_FFFF, 1, 0, 0, 0, 0, 10), 1'b1,
                    '{mhps_pkg::DRV_POS, 32'sh7FFF_FFFF, 1'b1, 1'b0, mhps_pkg::PH_FINDING}});
    tbl.push_back('{mk(mhps_pkg::REQ_TICK, 0, 0, 1, 0, 0, 0, 11), 1'b1,
                    '{mhps_pkg::DRV_DUTY, 32'sd0, 1'b0, 1'b0, mhps_pkg::PH_IDLE}});
    tbl.push_back('{mk(mhps_pkg::REQ_SETPT, 32'h8000_0000, 0, 0, 0, 0, 0, 12), 1'b1,
                    '{mhps_pkg::DRV_VEL, 32'sh8000_0000, 1'b0, 1'b0, mhps_pkg::PH_FINDING}});
    tbl.push_back('{mk(mhps_pkg::REQ_TICK, 0, 0, 0, 0, 0, 0, 13), 1'b0, '0});
    tbl.push_back('{mk(mhps_pkg::REQ_TICK, 0, 0, 0, 1, 32'h7FFF_FFFF, 0, 14), 1'b0, '0});
    tbl.push_back('{mk(mhps_pkg::REQ_SETPT, 32'h5_0000, 1, 0, 0, 0, 0, 15), 1'b0, '0});
    tbl.push_back('{mk(mhps_pkg::REQ_TICK, 0, 0, 0, 0, 32'h5_FFFF, 16'sd1000, 16),
                    1'b0, '0});
    tbl.push_back('{mk(mhps_pkg::REQ_TICK, 0, 0, 0, 0, 32'h5_FFFF, -16'sd999, 17),
                    1'b0, '0});
    tbl.push_back('{mk(mhps_pkg::REQ_SETPT, 32'h5_0000, 1, 0, 0, 0, 0, 18), 1'b0, '0});
    tbl.push_back('{mk(mhps_pkg::REQ_TICK, 0, 0, 0, 0, 32'h4_0000, 16'h8000, 19),
                    1'b0, '0});
    tbl.push_back('{mk(mhps_pkg::REQ_STOP, 0, 0, 0, 0, 0, 0, 20), 1'b1,
                    '{mhps_pkg::DRV_DUTY, 32'sd0, 1'b0, 1'b0, mhps_pkg::PH_IDLE}});
    tbl.push_back('{mk(mhps_pkg::REQ_HOME, 0, 0, 0, 0, 0, 0, 100), 1'b0, '0});
    tbl.push_back('{mk(mhps_pkg::REQ_TICK, 0, 0, 0, 0, 0, 0, 101), 1'b0, '0});
    tbl.push_back('{mk(mhps_pkg::REQ_TICK, 0, 0, 0, 1, 0, 0, 102), 1'b0, '0});
    tbl.push_back('{mk(mhps_pkg::REQ_TICK, 0, 0, 0, 1, 0, 0, 103), 1'b0, '0});
    tbl.push_back('{mk(mhps_pkg::REQ_TICK, 0, 0, 0, 0, 0, 0, 104), 1'b0, '0});
    tbl.push_back('{mk(mhps_pkg::REQ_MAN_FWD, 0, 0, 0, 0, 0, 0, 105), 1'b0, '0});
    tbl.push_back('{mk(mhps_pkg::REQ_TICK, 0, 0, 0, 0, 0, 0, 106), 1'b0, '0});
    tbl.push_back('{mk(mhps_pkg::REQ_TICK, 0, 0, 1, 0, 0, 0, 107), 1'b0, '0});
    tbl.push_back('{mk(mhps_pkg::REQ_MAN_REV, 0, 0, 0, 0, 0, 0, 108), 1'b0, '0});
    tbl.push_back('{mk(mhps_pkg::REQ_TICK, 0, 0, 0, 0, 0, 0, 109), 1'b0, '0});
    tbl.push_back('{mk(mhps_pkg::REQ_TICK, 0, 0, 0, 1, 0, 0, 110), 1'b0, '0});

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (tbl[i]) send_beat(tbl[i].beat, tbl[i].typed, tbl[i].want);

    for (int p = 0; p < N_PHASES; p++) begin
      drain();
      load_cfg(pick_cfg(p));
      if (p % 4 == 3) begin
        gap_pct   = 0;
        stall_pct = 0;
      end else begin
        gap_pct   = $urandom_range(5, 60);
        stall_pct = $urandom_range(5, 60);
      end
      // Some phases start just short of the millisecond counter wrapping.
      if ($urandom_range(0, 2) == 0) now_ms = 32'hFFFF_FF00 + $urandom_range(0, 255);
      base = n_beats;
      while (n_beats - base < BEATS_PER_PHASE) run_sequence();
    end

    drain();
    repeat (8) @(posedge clk);
    if (n_errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
